/* rtl/cdq_pkg.sv */
// cdq_pkg: operation and status codes and the per-beat result metadata
// shared by the circular deque control, pipeline and interfaces
// no dependencies
`default_nettype none

package cdq_pkg;

   localparam int unsigned OP_WIDTH     = 3;
   localparam int unsigned VALUE_WIDTH  = 32;
   localparam int unsigned STATUS_WIDTH = 2;
   localparam int unsigned COUNT_WIDTH  = 7;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_PUSH_REAR  = 3'd0,
      OP_POP_FRONT  = 3'd1,
      OP_PUSH_FRONT = 3'd2,
      OP_POP_REAR   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_REAR  = 3'd5
   } op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic                   rd;
      status_type             status;
      logic [COUNT_WIDTH-1:0] item_count;
      logic                   empty;
      logic                   full;
   } meta_type;

endpackage

`default_nettype wire

/* rtl/cdq_if.sv */
// cdq_req_if / cdq_rsp_if: valid/ready channels carrying deque operations and results
// depends on cdq_pkg
`default_nettype none

interface cdq_req_if;
   logic                                   valid;
   logic                                   ready;
   logic        [cdq_pkg::OP_WIDTH-1:0]    operation;
   logic signed [cdq_pkg::VALUE_WIDTH-1:0] value;

   modport source (output valid, output operation, output value, input ready);
   modport sink   (input valid, input operation, input value, output ready);
endinterface

interface cdq_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [cdq_pkg::VALUE_WIDTH-1:0]  data_out;
   logic        [cdq_pkg::STATUS_WIDTH-1:0] status;
   logic        [cdq_pkg::COUNT_WIDTH-1:0]  item_count;
   logic                                    is_empty_flag;
   logic                                    is_full_flag;

   modport source (output valid, output data_out, output status, output item_count,
                   output is_empty_flag, output is_full_flag, input ready);
   modport sink   (input valid, input data_out, input status, input item_count,
                   input is_empty_flag, input is_full_flag, output ready);
endinterface

`default_nettype wire

/* rtl/cdq_ram.sv */
// cdq_ram: generic single-clock ram, one write and one read port, registered read
// no dependencies
`default_nettype none

module cdq_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/cdq_ctrl.sv */
// cdq_ctrl: front/rear index registers, occupancy and status decode, ram command
// depends on cdq_pkg
`default_nettype none

module cdq_ctrl #(
   parameter int unsigned DEPTH      = 128,
   parameter int unsigned DATA_WIDTH = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   fire,
   input  wire logic        [cdq_pkg::OP_WIDTH-1:0]    operation,
   input  wire logic signed [cdq_pkg::VALUE_WIDTH-1:0] value,
   output logic                                        ram_we,
   output logic                                        ram_re,
   output logic             [$clog2(DEPTH)-1:0]        ram_addr,
   output logic             [DATA_WIDTH-1:0]           ram_wdata,
   output cdq_pkg::meta_type                           meta
);
   import cdq_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = AW + 1;
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [CW-1:0] FULL_C = CW'(DEPTH - 1);

   logic [AW-1:0] front_ff, front_in;
   logic [AW-1:0] rear_ff, rear_in;
   logic [CW-1:0] count, new_count;
   logic [AW-1:0] front_next, front_prev, rear_next, rear_prev;
   logic          cur_empty, cur_full, inc, dec, we, re;
   status_type    status;

   function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
      ring_next = (i == LAST) ? '0 : i + AW'(1);
   endfunction

   function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
      ring_prev = (i == '0) ? LAST : i - AW'(1);
   endfunction

   always_comb begin
      count = {1'b0, rear_ff} - {1'b0, front_ff} + ((rear_ff < front_ff) ? DEPTH_C : '0);
      cur_empty = (count == '0);
      cur_full  = (count == FULL_C);
      front_next = ring_next(front_ff);
      front_prev = ring_prev(front_ff);
      rear_next  = ring_next(rear_ff);
      rear_prev  = ring_prev(rear_ff);

      front_in = front_ff;
      rear_in  = rear_ff;
      ram_addr = rear_ff;
      we       = 1'b0;
      re       = 1'b0;
      inc      = 1'b0;
      dec      = 1'b0;
      status   = ST_OK;

      case (op_type'(operation))
         OP_PUSH_REAR: begin
            if (cur_full) begin
               status = ST_OVERFLOW;
            end else begin
               rear_in  = rear_next;
               ram_addr = rear_next;
               we       = 1'b1;
               inc      = 1'b1;
            end
         end
         OP_PUSH_FRONT: begin
            if (cur_full) begin
               status = ST_OVERFLOW;
            end else begin
               front_in = front_prev;
               ram_addr = front_ff;
               we       = 1'b1;
               inc      = 1'b1;
            end
         end
         OP_POP_FRONT: begin
            if (cur_empty) begin
               status = ST_UNDERFLOW;
            end else begin
               front_in = front_next;
               ram_addr = front_next;
               re       = 1'b1;
               dec      = 1'b1;
            end
         end
         OP_POP_REAR: begin
            if (cur_empty) begin
               status = ST_UNDERFLOW;
            end else begin
               rear_in  = rear_prev;
               ram_addr = rear_ff;
               re       = 1'b1;
               dec      = 1'b1;
            end
         end
         OP_PEEK_FRONT: begin
            if (cur_empty) begin
               status = ST_UNDERFLOW;
            end else begin
               ram_addr = front_next;
               re       = 1'b1;
            end
         end
         OP_PEEK_REAR: begin
            if (cur_empty) begin
               status = ST_UNDERFLOW;
            end else begin
               ram_addr = rear_ff;
               re       = 1'b1;
            end
         end
         default: begin
         end
      endcase

      new_count = count + (inc ? CW'(1) : '0) - (dec ? CW'(1) : '0);

      ram_we    = fire && we;
      ram_re    = fire && re;
      ram_wdata = DATA_WIDTH'(value);

      meta.rd         = re;
      meta.status     = status;
      meta.item_count = COUNT_WIDTH'(new_count);
      meta.empty      = (new_count == '0);
      meta.full       = (new_count == FULL_C);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         rear_ff  <= '0;
      end else if (fire) begin
         front_ff <= front_in;
         rear_ff  <= rear_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/circular_deque_core.sv */
// circular_deque_core: double-ended queue in a ring of DEPTH ram slots (DEPTH-1 usable)
// depends on cdq_pkg, cdq_req_if, cdq_rsp_if, cdq_ctrl, cdq_ram
//
// req_chan carries one operation per beat (push/pop at either end, peek at either end);
// rsp_chan returns exactly one result beat per operation, in order: popped or peeked
// data, status (ok, overflow, underflow), item count and empty/full flags after it.
// from the accepted request beat, the first stage updates the indices and issues the
// ram access; the second stage registers the ram read data with the status into the
// output register. throughput: one operation per cycle when the receiver does not
// stall, set by the single ram port access per beat; a write is visible to a read
// issued in the following cycle, so no forwarding.
// reset clears the indices (deque empty) and both pipeline stages; slot contents
// are not cleared and are never read before being written.
// when the receiver stalls, the output register and the read stage each hold one
// beat; the request side then deasserts ready until the output drains.
`default_nettype none

module circular_deque_core #(
   parameter int unsigned DEPTH      = 128,
   parameter int unsigned DATA_WIDTH = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   cdq_req_if.sink   req_chan,
   cdq_rsp_if.source rsp_chan
);
   import cdq_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);

   logic                  fire;
   logic                  ram_we, ram_re;
   logic [AW-1:0]         ram_addr;
   logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
   meta_type              meta;

   logic                  s1_valid_ff;
   meta_type              s1_meta_ff;
   logic                  out_valid_ff;
   logic [VALUE_WIDTH-1:0] out_data_ff;
   meta_type              out_meta_ff;
   logic                  out_free, s1_adv;

   cdq_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .operation (req_chan.operation),
      .value     (req_chan.value),
      .ram_we    (ram_we),
      .ram_re    (ram_re),
      .ram_addr  (ram_addr),
      .ram_wdata (ram_wdata),
      .meta      (meta)
   );

   cdq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock      (clock),
      .wr_en      (ram_we),
      .wr_addr    (ram_addr),
      .wr_data    (ram_wdata),
      .rd_en      (ram_re),
      .rd_addr    (ram_addr),
      .rd_data_ff (ram_rdata)
   );

   always_comb begin
      out_free       = !out_valid_ff || rsp_chan.ready;
      s1_adv         = s1_valid_ff && out_free;
      req_chan.ready = !s1_valid_ff || s1_adv;
      fire           = req_chan.valid && req_chan.ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         s1_meta_ff <= meta;
      end
      if (s1_adv) begin
         out_meta_ff <= s1_meta_ff;
         out_data_ff <= s1_meta_ff.rd ? VALUE_WIDTH'(ram_rdata) : '0;
      end
   end

   always_comb begin
      rsp_chan.valid         = out_valid_ff;
      rsp_chan.data_out      = out_data_ff;
      rsp_chan.status        = out_meta_ff.status;
      rsp_chan.item_count    = out_meta_ff.item_count;
      rsp_chan.is_empty_flag = out_meta_ff.empty;
      rsp_chan.is_full_flag  = out_meta_ff.full;
   end

   // overflow only when the deque stays full
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status == ST_OVERFLOW |-> rsp_chan.is_full_flag)
      else $error("overflow reported while not full");

   // underflow leaves the deque empty and returns no data
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status == ST_UNDERFLOW
      |-> rsp_chan.is_empty_flag && rsp_chan.data_out == '0)
      else $error("underflow with data or nonempty deque");

   // a read stage beat blocked by the output register is not dropped
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_meta_ff))
      else $error("read stage beat lost under stall");

   // no ram read is issued while a blocked beat waits on the read data
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |-> !ram_re)
      else $error("ram read data overwritten under stall");

endmodule

`default_nettype wire

/* tb/deque_result_checker.sv */
// deque_result_checker: watches the request and result channels of circular_deque_core,
// predicts every result beat from its own copy of the ring and compares field by field
// depends on cdq_pkg, cdq_req_if, cdq_rsp_if
`timescale 1ns / 1ps

module deque_result_checker (
   input  logic clock,
   input  logic reset,
   cdq_req_if   req_mon,
   cdq_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_results
);
   import cdq_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = 7'd127;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] data;
      status_type             status;
      logic [COUNT_WIDTH-1:0] count;
      logic                   empty;
      logic                   full;
   } deque_result_type;

   logic [VALUE_WIDTH-1:0] ring [128];
   logic [COUNT_WIDTH-1:0] head_idx;
   logic [COUNT_WIDTH-1:0] tail_idx;
   deque_result_type       expected_results [$];
   int                     errors = 0;

   assign fail_count      = errors;
   assign pending_results = expected_results.size();

   task automatic note_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      if (errors < 50)
         $display("%0t ns: %s got %h want %h", $realtime, what, got, want);
      errors++;
   endtask

   function automatic deque_result_type apply_op(input logic [OP_WIDTH-1:0] op,
                                                 input logic [VALUE_WIDTH-1:0] val);
      deque_result_type       r;
      logic [COUNT_WIDTH-1:0] held;
      held     = tail_idx - head_idx;
      r        = '0;
      r.status = ST_OK;
      case (op)
         OP_PUSH_REAR, OP_PUSH_FRONT: begin
            if (held == FULL_COUNT) begin
               r.status = ST_OVERFLOW;
            end else if (op == OP_PUSH_REAR) begin
               tail_idx       = tail_idx + 7'd1;
               ring[tail_idx] = val;
            end else begin
               ring[head_idx] = val;
               head_idx       = head_idx - 7'd1;
            end
         end
         OP_POP_FRONT, OP_POP_REAR, OP_PEEK_FRONT, OP_PEEK_REAR: begin
            if (held == '0) begin
               r.status = ST_UNDERFLOW;
            end else if (op == OP_POP_FRONT) begin
               head_idx = head_idx + 7'd1;
               r.data   = ring[head_idx];
            end else if (op == OP_POP_REAR) begin
               r.data   = ring[tail_idx];
               tail_idx = tail_idx - 7'd1;
            end else if (op == OP_PEEK_FRONT) begin
               r.data = ring[head_idx + 7'd1];
            end else begin
               r.data = ring[tail_idx];
            end
         end
         default: ;
      endcase
      held    = tail_idx - head_idx;
      r.count = held;
      r.empty = (held == '0);
      r.full  = (held == FULL_COUNT);
      return r;
   endfunction

   always @(posedge clock) begin
      deque_result_type want;
      if (reset) begin
         head_idx = '0;
         tail_idx = '0;
         expected_results.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            expected_results.push_back(apply_op(req_mon.operation, req_mon.value));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               note_mismatch("unexpected result beat, data_out", rsp_mon.data_out, '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_mon.data_out !== want.data)
                  note_mismatch("data_out", rsp_mon.data_out, want.data);
               if (rsp_mon.status !== want.status)
                  note_mismatch("status", rsp_mon.status, want.status);
               if (rsp_mon.item_count !== want.count)
                  note_mismatch("item_count", rsp_mon.item_count, want.count);
               if (rsp_mon.is_empty_flag !== want.empty)
                  note_mismatch("is_empty_flag", rsp_mon.is_empty_flag, want.empty);
               if (rsp_mon.is_full_flag !== want.full)
                  note_mismatch("is_full_flag", rsp_mon.is_full_flag, want.full);
            end
         end
      end
   end

endmodule

/* tb/circular_deque_core_test.sv */
// circular_deque_core_test: drives deque operations into circular_deque_core with random
// idling on both channels; deque_result_checker predicts and compares the result beats
// depends on cdq_pkg, cdq_req_if, cdq_rsp_if, circular_deque_core, deque_result_checker
`timescale 1ns / 1ps

module circular_deque_core_test;
   import cdq_pkg::*;

   localparam logic [OP_WIDTH-1:0] OP_RESERVED_A = 3'd6;
   localparam logic [OP_WIDTH-1:0] OP_RESERVED_B = 3'd7;

   logic clock = 1'b0;
   logic reset;
   int   send_idle_pct = 15;
   int   recv_idle_pct = 86;
   int   mismatches;
   int   outstanding;

   cdq_req_if req_chan ();
   cdq_rsp_if rsp_chan ();

   circular_deque_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   deque_result_checker result_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .fail_count      (mismatches),
      .pending_results (outstanding)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   task automatic send_op(input logic [OP_WIDTH-1:0] op, input logic [VALUE_WIDTH-1:0] val);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.operation <= op;
      req_chan.value     <= val;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   function automatic logic [VALUE_WIDTH-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [OP_WIDTH-1:0] pick_op(input int push_pct);
      if ($urandom_range(0, 99) < push_pct)
         return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
      case ($urandom_range(0, 49))
         0: return OP_RESERVED_A;
         1: return OP_RESERVED_B;
         default: begin
            case ($urandom_range(0, 3))
               0:       return OP_POP_FRONT;
               1:       return OP_POP_REAR;
               2:       return OP_PEEK_FRONT;
               default: return OP_PEEK_REAR;
            endcase
         end
      endcase
   endfunction

   task automatic run_stretch(input int beats, input int push_pct);
      for (int i = 0; i < beats; i++)
         send_op(pick_op(push_pct), pick_value());
   endtask

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.operation <= OP_PUSH_REAR;
      req_chan.value     <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // underflow on every read form, then ignored codes while empty
      send_op(OP_POP_FRONT, 32'h1234_5678);
      send_op(OP_POP_REAR, '0);
      send_op(OP_PEEK_FRONT, '0);
      send_op(OP_PEEK_REAR, '0);
      send_op(OP_RESERVED_A, 32'hDEAD_BEEF);
      send_op(OP_RESERVED_B, '0);
      // extremes at both ends, front pushes wrap below slot zero
      send_op(OP_PUSH_REAR, 32'h7FFF_FFFF);
      send_op(OP_PUSH_FRONT, 32'h8000_0000);
      send_op(OP_PUSH_REAR, 32'h0000_0000);
      send_op(OP_PUSH_FRONT, 32'hFFFF_FFFF);
      send_op(OP_PEEK_FRONT, '0);
      send_op(OP_PEEK_REAR, '0);
      send_op(OP_RESERVED_A, 32'h0F0F_0F0F);
      send_op(OP_POP_FRONT, '0);
      send_op(OP_POP_REAR, '0);
      send_op(OP_POP_FRONT, '0);
      send_op(OP_POP_REAR, '0);
      send_op(OP_POP_FRONT, '0);
      send_op(OP_PUSH_REAR, 32'h5555_5555);
      send_op(OP_PUSH_FRONT, 32'hAAAA_AAAA);
      send_op(OP_POP_REAR, '0);
      send_op(OP_POP_REAR, '0);
      send_op(OP_RESERVED_B, 32'hFFFF_FFFF);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 15;
               recv_idle_pct = 86;
            end
            1: begin
               send_idle_pct = 86;
               recv_idle_pct = 15;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         // fill past full, churn, then drain past empty
         run_stretch(140, 97);
         run_stretch(20, 50);
         run_stretch(140, 3);
         req_chan.valid <= 1'b0;
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
